// ===== rtl/rpn_stack_evaluator_assert.svh =====
// ----------------------------------------------------------------------------
// RPN stack evaluator assertion macros
// Concurrent assertion wrappers used by the evaluator top level.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_EVALUATOR_ASSERT_SVH
`define RPN_STACK_EVALUATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define RSE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

`define RSE_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define RSE_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define RSE_ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ===== rtl/rse_pkg.sv =====
// ----------------------------------------------------------------------------
// RPN stack evaluator package
// Shared sizes, character codes, status codes and request types.
// ----------------------------------------------------------------------------
`default_nettype none

package rse_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int RAM_DEPTH   = STACK_DEPTH - 1;
  localparam int RAM_AW      = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int DIV_W       = 16;
  localparam int DIV_CNT_W   = $clog2(DIV_W);

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_FEW      = 3'd1;
  localparam logic [2:0] STAT_BADCHAR  = 3'd2;
  localparam logic [2:0] STAT_COUNT    = 3'd3;
  localparam logic [2:0] STAT_DIVZERO  = 3'd4;
  localparam logic [2:0] STAT_OVERFLOW = 3'd5;

  typedef enum logic [2:0] {
    K_NOP, K_DIGIT, K_ADD, K_SUB, K_MUL, K_DIV, K_BAD
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  digit;
    logic        last;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_OPND, ST_DIVW, ST_FIN
  } state_t;

  function automatic logic is_op(kind_t k);
    return (k == K_ADD) || (k == K_SUB) || (k == K_MUL) || (k == K_DIV);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rse_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rse_front.sv =====
// ----------------------------------------------------------------------------
// RPN stack evaluator front end
// Accepts characters, classifies them and queues requests for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_front (
  input  wire logic          push,
  output logic               full,
  input  wire logic [7:0]    char_code,
  input  wire logic          end_of_expr,
  input  wire logic          q_full,
  output logic               q_push,
  output rse_pkg::item_t     q_item
);

  import rse_pkg::*;

  logic       is_ws;
  logic       is_digit;
  logic [7:0] dval;
  kind_t      kind;

  assign is_ws    = ((char_code >= CH_TAB) && (char_code <= CH_CR)) || (char_code == CH_SPACE);
  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign dval     = char_code - CH_ZERO;

  always_comb begin
    kind = K_BAD;
    if (is_ws) begin
      kind = K_NOP;
    end else if (is_digit) begin
      kind = K_DIGIT;
    end else begin
      case (char_code)
        CH_PLUS:  kind = K_ADD;
        CH_MINUS: kind = K_SUB;
        CH_STAR:  kind = K_MUL;
        CH_SLASH: kind = K_DIV;
        default:  kind = K_BAD;
      endcase
    end
  end

  // drop whitespace unless it closes the expression
  assign full         = q_full;
  assign q_push       = push && !q_full && !(is_ws && !end_of_expr);
  assign q_item.kind  = kind;
  assign q_item.digit = dval[3:0];
  assign q_item.last  = end_of_expr;

endmodule

`default_nettype wire

// ===== rtl/rse_queue.sv =====
// ----------------------------------------------------------------------------
// RPN stack evaluator request queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire rse_pkg::item_t wdata,
  output logic                q_full,
  input  wire logic           rd,
  output rse_pkg::item_t      rdata,
  output logic                q_empty
);

  import rse_pkg::*;

  item_t      slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  logic       do_wr;
  logic       do_rd;

  assign q_full  = (fill == 2'd2);
  assign q_empty = (fill == 2'd0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rdata   = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_wr) begin
        wptr <= !wptr;
      end
      if (do_rd) begin
        rptr <= !rptr;
      end
      fill <= fill + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot[wptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rse_div.sv =====
// ----------------------------------------------------------------------------
// RPN stack evaluator divider
// Restoring divider on operand magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [rse_pkg::DIV_W-1:0]   dividend,
  input  wire logic [rse_pkg::DIV_W-1:0]   divisor,
  input  wire logic                        neg,
  output logic                             done,
  output logic [31:0]                      quotient
);

  import rse_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] step;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     dsr;
  logic                 neg_r;
  logic [DIV_W:0]       shifted;
  logic [DIV_W:0]       diff;
  logic [31:0]          qext;

  assign shifted  = {rem, quo[DIV_W-1]};
  assign diff     = shifted - {1'b0, dsr};
  assign qext     = {{(32 - DIV_W){1'b0}}, quo};
  assign quotient = neg_r ? (32'd0 - qext) : qext;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (step == DIV_CNT_W'(DIV_W - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= dividend;
      dsr   <= divisor;
      neg_r <= neg;
      step  <= '0;
    end else if (busy) begin
      step <= step + DIV_CNT_W'(1);
      if (!diff[DIV_W]) begin
        rem <= diff[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rse_back.sv =====
// ----------------------------------------------------------------------------
// RPN stack evaluator back end
// Executes queued requests on the operand stack and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_empty,
  input  wire rse_pkg::item_t q_item,
  output logic                q_pop,
  output logic                empty,
  input  wire logic           pop,
  output logic signed [31:0]  value,
  output logic [2:0]          status
);

  import rse_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;
  logic [2:0]            err;
  logic [2:0]            err_next;
  logic [31:0]           tos;
  logic [31:0]           tos_next;
  kind_t                 cur_kind;
  logic                  cur_last;
  logic                  out_valid;
  logic                  out_load;
  logic [31:0]           out_value;
  logic [2:0]            out_status;

  logic                  err_ok;
  logic                  few;
  logic                  out_free;
  logic                  ram_we;
  logic                  ram_re;
  logic [CNT_W-1:0]      widx;
  logic [CNT_W-1:0]      ridx;
  logic [31:0]           rdata;
  logic signed [15:0]    opa;
  logic signed [15:0]    opb;
  logic [31:0]           sum;
  logic [31:0]           dif;
  logic signed [31:0]    prod;
  logic [15:0]           mag_a;
  logic [15:0]           mag_b;
  logic                  div_start;
  logic                  div_done;
  logic [31:0]           div_q;
  logic [2:0]            fin_status;

  assign err_ok   = (err == STAT_OK);
  assign few      = (cnt < CNT_W'(2));
  assign out_free = !out_valid || pop;
  assign widx     = cnt - CNT_W'(1);
  assign ridx     = cnt - CNT_W'(2);

  assign opa   = rdata[15:0];
  assign opb   = tos[15:0];
  assign sum   = {{16{opa[15]}}, opa} + {{16{opb[15]}}, opb};
  assign dif   = {{16{opa[15]}}, opa} - {{16{opb[15]}}, opb};
  assign prod  = 32'(opa) * 32'(opb);
  assign mag_a = opa[15] ? (16'd0 - opa) : opa;
  assign mag_b = opb[15] ? (16'd0 - opb) : opb;

  assign fin_status = !err_ok ? err : ((cnt != CNT_W'(1)) ? STAT_COUNT : STAT_OK);

  rse_ram #(
    .WIDTH (32),
    .DEPTH (RAM_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx[RAM_AW-1:0]),
    .wdata (tos),
    .re    (ram_re),
    .raddr (ridx[RAM_AW-1:0]),
    .rdata (rdata)
  );

  rse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag_a),
    .divisor  (mag_b),
    .neg      (opa[15] ^ opb[15]),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          if (err_ok && is_op(q_item.kind) && !few) begin
            state_next = ST_OPND;
          end else if (q_item.last) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_OPND: begin
        if ((cur_kind == K_DIV) && (opb != 16'sd0)) begin
          state_next = ST_DIVW;
        end else begin
          state_next = cur_last ? ST_FIN : ST_IDLE;
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          state_next = cur_last ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    cnt_next  = cnt;
    err_next  = err;
    tos_next  = tos;
    case (state)
      ST_IDLE: begin
        q_pop = !q_empty;
        if (!q_empty && err_ok) begin
          case (q_item.kind)
            K_DIGIT: begin
              if (cnt == CNT_W'(STACK_DEPTH)) begin
                err_next = STAT_OVERFLOW;
              end else begin
                ram_we   = (cnt != '0);
                tos_next = {28'd0, q_item.digit};
                cnt_next = cnt + CNT_W'(1);
              end
            end
            K_ADD, K_SUB, K_MUL, K_DIV: begin
              if (few) begin
                err_next = STAT_FEW;
              end else begin
                ram_re = 1'b1;
              end
            end
            K_BAD:   err_next = STAT_BADCHAR;
            default: err_next = err;
          endcase
        end
      end
      ST_OPND: begin
        case (cur_kind)
          K_ADD: begin
            tos_next = sum;
            cnt_next = cnt - CNT_W'(1);
          end
          K_SUB: begin
            tos_next = dif;
            cnt_next = cnt - CNT_W'(1);
          end
          K_MUL: begin
            tos_next = prod;
            cnt_next = cnt - CNT_W'(1);
          end
          K_DIV: begin
            if (opb == 16'sd0) begin
              err_next = STAT_DIVZERO;
            end else begin
              div_start = 1'b1;
            end
          end
          default: tos_next = tos;
        endcase
      end
      ST_DIVW: begin
        if (div_done) begin
          tos_next = div_q;
          cnt_next = cnt - CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          cnt_next = '0;
          err_next = STAT_OK;
        end
      end
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      err       <= STAT_OK;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      err   <= err_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tos <= tos_next;
    if (q_pop) begin
      cur_kind <= q_item.kind;
      cur_last <= q_item.last;
    end
    if (out_load) begin
      out_status <= fin_status;
      out_value  <= (fin_status == STAT_OK) ? tos : 32'd0;
    end
  end

  assign empty  = !out_valid;
  assign value  = out_value;
  assign status = out_status;

endmodule

`default_nettype wire

// ===== rtl/rpn_stack_evaluator.sv =====
// ----------------------------------------------------------------------------
// RPN stack evaluator
// Takes one character of a reverse Polish expression per request and, on the
// character flagged as last, offers one result (value and status). A front
// end classifies characters into a two-entry queue; a back end runs them on a
// stack whose top sits in a register and whose lower entries sit in a RAM.
// Whitespace that does not end the expression never reaches the back end. A
// digit is pushed onto the stack; + - * first read the lower operand from the
// RAM, then apply the operation; / reads the lower operand, then waits for the
// sixteen-step divider. The final character then loads the result register,
// which holds one result; the back end waits there while an older result is
// still not taken. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rpn_stack_evaluator_assert.svh"

module rpn_stack_evaluator (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic [7:0]    char_code,
  input  wire logic          end_of_expr,
  output logic               empty,
  input  wire logic          pop,
  output logic signed [31:0] value,
  output logic [2:0]         status
);

  import rse_pkg::*;

  logic  q_full;
  logic  q_empty;
  logic  q_push;
  logic  q_pop;
  item_t f_item;
  item_t b_item;

  rse_front u_front (
    .push        (push),
    .full        (full),
    .char_code   (char_code),
    .end_of_expr (end_of_expr),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (f_item)
  );

  rse_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wdata   (f_item),
    .q_full  (q_full),
    .rd      (q_pop),
    .rdata   (b_item),
    .q_empty (q_empty)
  );

  rse_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_item  (b_item),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .value   (value),
    .status  (status)
  );

  `RSE_ASSERT_IMP(a_err_zero_value, clk, rst, !empty && (status != STAT_OK), value == 32'sd0)
  `RSE_ASSERT_NEVER(a_pop_when_empty, clk, rst, q_pop && q_empty)
  `RSE_ASSERT_NEVER(a_push_when_full, clk, rst, q_push && q_full)

endmodule

`default_nettype wire
